[rtl/periodic_table_interpolator_defines.svh]
// Assertion macros for the periodic table interpolator
`ifndef PERIODIC_TABLE_INTERPOLATOR_DEFINES_SVH
`define PERIODIC_TABLE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication
`define PTI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define PTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pti_pkg.sv]
// Shared constants and controller/datapath interface types
package pti_pkg;
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int TIME_W = 47;
    localparam int QT_W   = 48;
    localparam int COMP_W = 32;
    localparam int NCOMP  = 6;
    localparam int K_W    = 3;
    localparam int WBITS  = 30;
    localparam int DW     = TIME_W + 3;
    localparam logic [TIME_W-1:0] PERIOD_RESET = TIME_W'(65536);
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [NCOMP-1:0][COMP_W-1:0] t_comp;

    typedef struct packed {
        logic           load_we;
        logic           q_init;
        logic           mod_step;
        logic           mod_fix;
        logic           srch_rd;
        logic           srch_cmp;
        logic           fetch_a;
        logic           fetch_b;
        logic           latch_b;
        logic           setup;
        logic           decide;
        logic           div_step;
        logic           mul;
        logic           acc;
        logic [K_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic srch_done;
        logic div_bypass;
    } t_status;
endpackage

[rtl/pti_ctrl.sv]
// Controller state machine sequencing one load or query item
module pti_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_cmd,
    input  pti_pkg::t_status i_status,
    output pti_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_valid
);
    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_MOD      = 14'b00000000000010,
        S_MOD_FIX  = 14'b00000000000100,
        S_SRCH_RD  = 14'b00000000001000,
        S_SRCH_CMP = 14'b00000000010000,
        S_FETCH_A  = 14'b00000000100000,
        S_FETCH_B  = 14'b00000001000000,
        S_LATCH_B  = 14'b00000010000000,
        S_SETUP    = 14'b00000100000000,
        S_DECIDE   = 14'b00001000000000,
        S_DIV      = 14'b00010000000000,
        S_MUL      = 14'b00100000000000,
        S_ACC      = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [pti_pkg::K_W-1:0] r_k, n_k;
    logic accept;

    assign accept  = i_start && (r_state == S_IDLE);
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    // Decode commands and advance state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.k = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_cmd == pti_pkg::CMD_LOAD) begin
                    o_cmd.load_we = 1'b1;
                end else if (accept) begin
                    o_cmd.q_init = 1'b1;
                    n_cnt   = '0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(pti_pkg::QT_W - 1)) n_state = S_MOD_FIX;
            end
            S_MOD_FIX: begin
                o_cmd.mod_fix = 1'b1;
                n_state = S_SRCH_RD;
            end
            S_SRCH_RD: begin
                if (i_status.srch_done) begin
                    n_state = S_FETCH_A;
                end else begin
                    o_cmd.srch_rd = 1'b1;
                    n_state = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state = S_SRCH_RD;
            end
            S_FETCH_A: begin
                o_cmd.fetch_a = 1'b1;
                n_state = S_FETCH_B;
            end
            S_FETCH_B: begin
                o_cmd.fetch_b = 1'b1;
                n_state = S_LATCH_B;
            end
            S_LATCH_B: begin
                o_cmd.latch_b = 1'b1;
                n_state = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_cnt = '0;
                n_k   = '0;
                n_state = i_status.div_bypass ? S_MUL : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(pti_pkg::WBITS - 1)) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_k = r_k + 1'b1;
                n_state = (r_k == pti_pkg::K_W'(pti_pkg::NCOMP - 1)) ? S_DONE : S_MUL;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
        end
    end
endmodule

[rtl/pti_datapath.sv]
// Datapath: sample memories, modulo, search, weight divider and interpolation
module pti_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pti_pkg::t_cmd                      i_cmd,
    output pti_pkg::t_status                   o_status,
    input  logic                               i_cfg_we,
    input  logic [pti_pkg::TIME_W-1:0]         i_cfg_data,
    input  logic [pti_pkg::IDX_W-1:0]          i_entry_index,
    input  logic [pti_pkg::TIME_W-1:0]         i_entry_time,
    input  pti_pkg::t_comp                     i_entry_comp,
    input  logic signed [pti_pkg::QT_W-1:0]    i_query_time,
    output pti_pkg::t_comp                     o_res
);
    localparam int TW = pti_pkg::TIME_W;
    localparam int QW = pti_pkg::QT_W;
    localparam int DW = pti_pkg::DW;
    localparam int IW = pti_pkg::IDX_W;
    localparam int CW = pti_pkg::COMP_W;
    localparam logic [IW:0]   ENTRIES = (IW+1)'(pti_pkg::TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST    = IW'(pti_pkg::TABLE_ENTRIES - 1);

    // Sample memories
    logic [TW-1:0] time_mem [pti_pkg::TABLE_ENTRIES];
    pti_pkg::t_comp comp_mem [pti_pkg::TABLE_ENTRIES];
    logic [TW-1:0]  r_tm_rd;
    pti_pkg::t_comp r_cm_rd;

    logic [TW-1:0] r_period;
    logic          r_neg;
    logic [QW-1:0] r_dvd;
    logic [TW-1:0] r_mrem;
    logic [TW-1:0] r_t;
    logic [IW:0]   r_lo, r_hi;
    logic [TW-1:0] r_t0raw, r_t1raw;
    pti_pkg::t_comp r_c0, r_c1;
    logic signed [DW-1:0] r_d, r_u;
    logic [TW:0]          r_wrem;
    logic [pti_pkg::WBITS:0] r_w;
    logic signed [63:0]   r_prod;
    pti_pkg::t_comp       r_res;

    logic [IW+1:0] mid_sum;
    logic [IW-1:0] mid, a_idx, b_idx, rd_addr;
    logic [QW-1:0] mod_tmp;
    logic [TW+1:0] div_tmp;
    logic signed [DW-1:0] t0, t1, tq;
    logic signed [CW:0]   diff;
    logic signed [CW+31:0] prod_full;
    logic signed [63:0]   rnd;
    logic [63:0]          sh;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[IW:1];
    assign a_idx   = (r_lo == '0 || r_lo == ENTRIES) ? LAST : IW'(r_lo - 1'b1);
    assign b_idx   = (r_lo == ENTRIES) ? '0 : r_lo[IW-1:0];
    assign rd_addr = i_cmd.fetch_a ? a_idx : (i_cmd.fetch_b ? b_idx : mid);

    assign o_status.srch_done  = (r_lo == r_hi);
    assign o_status.div_bypass = (r_d <= 0) || (r_u <= 0) || (r_u >= r_d);

    assign mod_tmp = {r_mrem, r_dvd[QW-1]};
    assign div_tmp = {r_wrem, 1'b0};
    assign t0 = DW'({1'b0, r_t0raw}) - ((r_lo == '0) ? DW'({1'b0, r_period}) : DW'(0));
    assign t1 = (r_lo == ENTRIES) ? DW'({1'b0, r_period}) : DW'({1'b0, r_t1raw});
    assign tq = DW'({1'b0, r_t});
    assign diff = {r_c1[i_cmd.k][CW-1], r_c1[i_cmd.k]} - {r_c0[i_cmd.k][CW-1], r_c0[i_cmd.k]};
    assign prod_full = diff * $signed({1'b0, r_w});
    assign rnd = r_prod + 64'sd536870912;
    assign sh  = 64'(rnd >>> pti_pkg::WBITS);
    assign o_res = r_res;

    // Write and read the sample memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            time_mem[i_entry_index] <= i_entry_time;
            comp_mem[i_entry_index] <= i_entry_comp;
        end
        r_tm_rd <= time_mem[rd_addr];
        r_cm_rd <= comp_mem[rd_addr];
    end

    // Hold the period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= pti_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_data;
        end
    end

    // Reduce time, search, fetch, divide and interpolate
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_init) begin
            r_neg  <= i_query_time[QW-1];
            r_dvd  <= i_query_time[QW-1] ? QW'(-i_query_time) : QW'(i_query_time);
            r_mrem <= '0;
        end
        if (i_cmd.mod_step) begin
            r_dvd <= {r_dvd[QW-2:0], 1'b0};
            if (mod_tmp >= {1'b0, r_period}) r_mrem <= TW'(mod_tmp - {1'b0, r_period});
            else r_mrem <= mod_tmp[TW-1:0];
        end
        if (i_cmd.mod_fix) begin
            if (r_period == '0) r_t <= '0;
            else if (r_neg && r_mrem != '0) r_t <= r_period - r_mrem;
            else r_t <= r_mrem;
            r_lo <= '0;
            r_hi <= ENTRIES;
        end
        if (i_cmd.srch_cmp) begin
            if (r_tm_rd <= r_t) r_lo <= {1'b0, mid} + 1'b1;
            else r_hi <= {1'b0, mid};
        end
        if (i_cmd.fetch_b) begin
            r_t0raw <= r_tm_rd;
            r_c0    <= r_cm_rd;
        end
        if (i_cmd.latch_b) begin
            r_t1raw <= r_tm_rd;
            r_c1    <= r_cm_rd;
        end
        if (i_cmd.setup) begin
            r_d <= t1 - t0;
            r_u <= tq - t0;
        end
        if (i_cmd.decide) begin
            r_w    <= (r_d > 0 && r_u >= r_d) ? (pti_pkg::WBITS+1)'(1 << pti_pkg::WBITS) : '0;
            r_wrem <= r_u[TW:0];
        end
        if (i_cmd.div_step) begin
            if (div_tmp >= r_d[TW+1:0]) begin
                r_wrem <= (TW+1)'(div_tmp - r_d[TW+1:0]);
                r_w    <= {r_w[pti_pkg::WBITS-1:0], 1'b1};
            end else begin
                r_wrem <= div_tmp[TW:0];
                r_w    <= {r_w[pti_pkg::WBITS-1:0], 1'b0};
            end
        end
        if (i_cmd.mul) r_prod <= prod_full[63:0];
        if (i_cmd.acc) r_res[i_cmd.k] <= r_c0[i_cmd.k] + sh[CW-1:0];
    end
endmodule

[rtl/periodic_table_interpolator.sv]
// A query item runs the modulo reduction, the binary search, the fetch and setup, the weight
// divider (skipped at segment ends and for empty or reversed segments), the interpolation and the output.
// A query item holds busy until its result; the next item is taken the cycle after.
// A load item is written in the cycle it is taken and leaves the block idle.
// Each result strobes o_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears control state, sets the period to 1.0; memories undefined.
`include "periodic_table_interpolator_defines.svh"
module periodic_table_interpolator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [pti_pkg::TIME_W-1:0]      i_cfg_data,
    input  logic                            i_cmd,
    input  logic [pti_pkg::IDX_W-1:0]       i_entry_index,
    input  logic [pti_pkg::TIME_W-1:0]      i_entry_time,
    input  logic signed [31:0]              i_entry_pos_x,
    input  logic signed [31:0]              i_entry_pos_y,
    input  logic signed [31:0]              i_entry_pos_z,
    input  logic signed [31:0]              i_entry_vel_x,
    input  logic signed [31:0]              i_entry_vel_y,
    input  logic signed [31:0]              i_entry_vel_z,
    input  logic signed [pti_pkg::QT_W-1:0] i_query_time,
    output logic                            o_valid,
    output logic signed [31:0]              o_pos_x,
    output logic signed [31:0]              o_pos_y,
    output logic signed [31:0]              o_pos_z,
    output logic signed [31:0]              o_vel_x,
    output logic signed [31:0]              o_vel_y,
    output logic signed [31:0]              o_vel_z
);
    pti_pkg::t_cmd    cmd;
    pti_pkg::t_status status;
    pti_pkg::t_comp   res;

    // Sequence the item
    pti_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // Compute the result
    pti_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_entry_time  (i_entry_time),
        .i_entry_comp  ({i_entry_vel_z, i_entry_vel_y, i_entry_vel_x,
                         i_entry_pos_z, i_entry_pos_y, i_entry_pos_x}),
        .i_query_time  (i_query_time),
        .o_res         (res)
    );

    assign o_pos_x = res[0];
    assign o_pos_y = res[1];
    assign o_pos_z = res[2];
    assign o_vel_x = res[3];
    assign o_vel_y = res[4];
    assign o_vel_z = res[5];

    `PTI_ASSERT_NEXT(a_valid_pulse, o_valid, !o_valid, "result strobe longer than one cycle")
    `PTI_ASSERT_NEXT(a_load_free, start && !busy && i_cmd == pti_pkg::CMD_LOAD, !busy && !o_valid, "load item occupied the block")
    `PTI_ASSERT_NEXT(a_query_busy, start && !busy && i_cmd == pti_pkg::CMD_QUERY, busy, "query item not taken up")
    `PTI_ASSERT_NOW(a_valid_busy, o_valid, busy, "result outside a query")
endmodule

[tb/tb_top.sv]
// Self-checking testbench for the periodic table interpolator
`timescale 1ns / 100ps
module tb_top;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic                       cmd;
        logic [pti_pkg::IDX_W-1:0]  idx;
        logic [pti_pkg::TIME_W-1:0] tm;
        pti_pkg::t_comp             comps;
        logic [pti_pkg::QT_W-1:0]   qt;
        bit                         typed;
        pti_pkg::t_comp             want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [pti_pkg::TIME_W-1:0] i_cfg_data = '0;
    logic i_cmd = pti_pkg::CMD_LOAD;
    logic [pti_pkg::IDX_W-1:0] i_entry_index = '0;
    logic [pti_pkg::TIME_W-1:0] i_entry_time = '0;
    logic signed [31:0] i_entry_pos_x = '0, i_entry_pos_y = '0, i_entry_pos_z = '0;
    logic signed [31:0] i_entry_vel_x = '0, i_entry_vel_y = '0, i_entry_vel_z = '0;
    logic signed [pti_pkg::QT_W-1:0] i_query_time = '0;
    logic o_valid;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z;

    // Shadow copy of the table and the period
    logic [pti_pkg::TIME_W-1:0] shadow_times [pti_pkg::TABLE_ENTRIES];
    pti_pkg::t_comp             shadow_comps [pti_pkg::TABLE_ENTRIES];
    logic [pti_pkg::TIME_W-1:0] shadow_period;

    pti_pkg::t_comp pending_results [$];
    t_stim_row      directed_rows [$];
    int        fail_count = 0;
    int        query_count = 0;
    int        load_count = 0;
    int        cycle_count = 0;
    int        idle_pct = 0;

    periodic_table_interpolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .i_cmd(i_cmd),
        .i_entry_index(i_entry_index), .i_entry_time(i_entry_time),
        .i_entry_pos_x(i_entry_pos_x), .i_entry_pos_y(i_entry_pos_y),
        .i_entry_pos_z(i_entry_pos_z), .i_entry_vel_x(i_entry_vel_x),
        .i_entry_vel_y(i_entry_vel_y), .i_entry_vel_z(i_entry_vel_z),
        .i_query_time(i_query_time), .o_valid(o_valid),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_vel_x(o_vel_x), .o_vel_y(o_vel_y), .o_vel_z(o_vel_z)
    );

    always #5 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t with %0d results pending", $time, pending_results.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Restoring division for the Q1.30 segment weight
    function automatic longint seg_weight(longint u, longint d);
        longint rem, w;
        w = 0;
        if (u <= 0) return 0;
        if (u >= d) return longint'(1) << pti_pkg::WBITS;
        rem = u;
        for (int i = 0; i < pti_pkg::WBITS; i++) begin
            rem = rem << 1;
            w = w << 1;
            if (rem >= d) begin
                rem = rem - d;
                w = w | 1;
            end
        end
        return w;
    endfunction

    // Interpolate the shadow table at a signed query time
    function automatic pti_pkg::t_comp interpolate_at(logic [pti_pkg::QT_W-1:0] qt);
        longint per, t, t0, t1, d, u, w, c0, c1;
        int lo, hi, mid, a, b;
        pti_pkg::t_comp res;
        per = longint'(shadow_period);
        t = longint'($signed(qt));
        if (per > 0) begin
            t = t % per;
            if (t < 0) t = t + per;
        end else begin
            t = 0;
        end
        lo = 0;
        hi = pti_pkg::TABLE_ENTRIES;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (longint'(shadow_times[mid]) <= t) lo = mid + 1;
            else hi = mid;
        end
        if (lo >= pti_pkg::TABLE_ENTRIES) begin
            a = pti_pkg::TABLE_ENTRIES - 1; b = 0;
            t0 = longint'(shadow_times[a]);
            t1 = per;
        end else if (lo == 0) begin
            a = pti_pkg::TABLE_ENTRIES - 1; b = 0;
            t0 = longint'(shadow_times[a]) - per;
            t1 = longint'(shadow_times[0]);
        end else begin
            a = lo - 1; b = lo;
            t0 = longint'(shadow_times[a]);
            t1 = longint'(shadow_times[b]);
        end
        d = t1 - t0;
        u = t - t0;
        w = (d > 0) ? seg_weight(u, d) : 0;
        for (int k = 0; k < pti_pkg::NCOMP; k++) begin
            c0 = longint'($signed(shadow_comps[a][k]));
            c1 = longint'($signed(shadow_comps[b][k]));
            res[k] = pti_pkg::COMP_W'(c0 + (((c1 - c0) * w +
                     (longint'(1) << (pti_pkg::WBITS - 1))) >>> pti_pkg::WBITS));
        end
        return res;
    endfunction

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        pti_pkg::t_comp got, want;
        if (i_rst_n && o_valid) begin
            got = {o_vel_z, o_vel_y, o_vel_x, o_pos_z, o_pos_y, o_pos_x};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                for (int k = 0; k < pti_pkg::NCOMP; k++)
                    if (got[k] !== want[k]) begin
                        $display("%0t: component %0d expected %h actual %h",
                                 $time, k, want[k], got[k]);
                        fail_count++;
                    end
            end
        end
    end

    function automatic pti_pkg::t_comp rand_comps();
        pti_pkg::t_comp c;
        for (int k = 0; k < pti_pkg::NCOMP; k++)
            case ($urandom_range(7))
                0: c[k] = 32'h7FFF_FFFF;
                1: c[k] = 32'h8000_0000;
                default: c[k] = $urandom;
            endcase
        return c;
    endfunction

    function automatic logic [pti_pkg::QT_W-1:0] rand_qtime();
        case ($urandom_range(3))
            0: return pti_pkg::QT_W'($urandom_range(0, 2 * int'(shadow_period[15:0]) + 8));
            1: return pti_pkg::QT_W'(shadow_period) * pti_pkg::QT_W'($urandom_range(0, 3)) -
                      pti_pkg::QT_W'($urandom_range(2));
            default: return pti_pkg::QT_W'({$urandom, $urandom});
        endcase
    endfunction

    // Drive one item and wait until the block takes it
    task automatic send_item(t_stim_row r);
        i_cmd <= r.cmd;
        i_entry_index <= r.idx;
        i_entry_time <= r.tm;
        {i_entry_vel_z, i_entry_vel_y, i_entry_vel_x,
         i_entry_pos_z, i_entry_pos_y, i_entry_pos_x} <= r.comps;
        i_query_time <= r.qt;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (r.cmd == pti_pkg::CMD_LOAD) begin
            shadow_times[r.idx] = r.tm;
            shadow_comps[r.idx] = r.comps;
            load_count++;
        end else begin
            pending_results.push_back(r.typed ? r.want : interpolate_at(r.qt));
            query_count++;
        end
        @(negedge i_clk);
        // Idle the sender now and then
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    endtask

    task automatic load_entry(int idx, logic [pti_pkg::TIME_W-1:0] tm, pti_pkg::t_comp c);
        t_stim_row r;
        r = '{pti_pkg::CMD_LOAD, pti_pkg::IDX_W'(idx), tm, c, '0, 1'b0, '0};
        send_item(r);
    endtask

    task automatic query_at(logic [pti_pkg::QT_W-1:0] qt);
        t_stim_row r;
        r = '{pti_pkg::CMD_QUERY, '0, '0, rand_comps(), qt, 1'b0, '0};
        send_item(r);
    endtask

    // Drain, hold off, then write the period
    task automatic write_period(logic [pti_pkg::TIME_W-1:0] p);
        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (150) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= p;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_period = p;
    endtask

    // Fill every slot; ordered times spread over the period, or scrambled
    task automatic fill_table(bit scrambled);
        logic [pti_pkg::TIME_W-1:0] tm;
        for (int i = 0; i < pti_pkg::TABLE_ENTRIES; i++) begin
            if (scrambled)
                tm = pti_pkg::TIME_W'({$urandom, $urandom});
            else
                tm = pti_pkg::TIME_W'((longint'(shadow_period) * i) / pti_pkg::TABLE_ENTRIES);
            load_entry(i, tm, rand_comps());
        end
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 30)
                load_entry($urandom_range(pti_pkg::TABLE_ENTRIES - 1),
                           ($urandom_range(3) == 0) ? pti_pkg::TIME_W'({$urandom, $urandom}) :
                           pti_pkg::TIME_W'((longint'(shadow_period) *
                                             $urandom_range(1023)) / 1024),
                           rand_comps());
            else
                query_at(rand_qtime());
        end
    endtask

    initial begin
        pti_pkg::t_comp hi_c, lo_c, z_c;
        t_stim_row r;
        hi_c = {pti_pkg::NCOMP{32'h7FFF_FFFF}};
        lo_c = {pti_pkg::NCOMP{32'h8000_0000}};
        z_c = '0;
        shadow_period = pti_pkg::PERIOD_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset period: evenly spaced table, then directed rows
        fill_table(1'b0);
        directed_rows.push_back('{pti_pkg::CMD_LOAD, 10'd0, 47'd0, z_c, '0, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_LOAD, 10'd10, 47'd640, hi_c, '0, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_LOAD, 10'd11, 47'd704, lo_c, '0, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_LOAD, 10'd20, 47'd1400, hi_c, '0, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_LOAD, 10'd21, 47'd1344, lo_c, '0, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_LOAD, 10'd30, 47'd1984, lo_c, '0, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_LOAD, 10'd31, 47'd1984, hi_c, '0, 0, '0});
        // Exact sample times return that sample
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, 48'd0, 1, z_c});
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, 48'd640, 1, hi_c});
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, 48'd704, 1, lo_c});
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, 48'd65536, 1, z_c});
        // Mid segment, reversed and empty segments, wrap and extremes
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, 48'd672, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, 48'd703, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, 48'd1380, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, 48'd1990, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, 48'd65500, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, -48'sd1, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, 48'h7FFF_FFFF_FFFF, 0, '0});
        directed_rows.push_back('{pti_pkg::CMD_QUERY, '0, '0, z_c, 48'h8000_0000_0000, 0, '0});
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            send_item(r);
        end

        // Random phases across period settings and idle patterns
        idle_pct = 35;
        run_random(150);
        write_period(47'd1);
        run_random(80);
        write_period(47'h7FFF_FFFF_FFFF);
        idle_pct = 74;
        run_random(120);
        write_period(pti_pkg::TIME_W'({$urandom_range(255), $urandom, 7'd0}));
        idle_pct = 0;
        run_random(150);
        write_period(47'd0);
        run_random(50);

        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (200) @(negedge i_clk);
        $display("covered %0d loads and %0d queries over periods of zero, one, reset,",
                 load_count, query_count);
        $display("a random value and the 47-bit maximum, with ordered and scattered sample times");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
